### sv/offer_packet_parser_macros.svh
// Assertion macros for the offer packet parser.
// Used by the queue and the result sequencer; no other dependencies.
`ifndef OFFER_PACKET_PARSER_MACROS_SVH
`define OFFER_PACKET_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define OPP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("offer packet parser check failed");

`define OPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("offer packet parser check failed");

`else

`define OPP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define OPP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### sv/opp_pkg.sv
// Types and constants shared by the offer packet parser modules.
// No dependencies.
package opp_pkg;

   localparam logic [7:0] SizeBytes = 8'd8;

   localparam logic [7:0] DeviceLimitReset = 8'd32;
   localparam logic [7:0] FileLimitReset   = 8'd64;
   localparam logic [7:0] FolderLimitReset = 8'd64;

   localparam logic [1:0] CSR_DEVICE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_FILE_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_FOLDER_LIMIT = 2'd2;

   localparam logic       KIND_CHAR    = 1'b0;
   localparam logic       KIND_VERDICT = 1'b1;

   localparam logic [1:0] STR_DEVICE = 2'd0;
   localparam logic [1:0] STR_FILE   = 2'd1;
   localparam logic [1:0] STR_FOLDER = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_HEAD  = 2'd1;
   localparam logic [1:0] ST_LIMIT = 2'd2;
   localparam logic [1:0] ST_TAIL  = 2'd3;

   typedef enum logic [11:0] {
      PH_SIZE      = 12'b0000_0000_0001,
      PH_DEV_LEN   = 12'b0000_0000_0010,
      PH_DEV_STR   = 12'b0000_0000_0100,
      PH_NAME_LEN  = 12'b0000_0000_1000,
      PH_NAME_STR  = 12'b0000_0001_0000,
      PH_FOLD_LEN  = 12'b0000_0010_0000,
      PH_FOLD_STR  = 12'b0000_0100_0000,
      PH_GIDX      = 12'b0000_1000_0000,
      PH_GCNT      = 12'b0001_0000_0000,
      PH_GTOT      = 12'b0010_0000_0000,
      PH_DONE      = 12'b0100_0000_0000,
      PH_FAIL      = 12'b1000_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_packet;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  string_field;
      logic [7:0]  char_index;
      logic [7:0]  char_value;
      logic [63:0] file_size;
      logic [7:0]  group_index;
      logic [7:0]  group_count;
      logic [63:0] group_total_bytes;
      logic [1:0]  status;
      logic        last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic        has_char;
      logic        has_verdict;
      logic [1:0]  string_field;
      logic [7:0]  char_index;
      logic [7:0]  char_value;
      logic [63:0] file_size;
      logic [7:0]  group_index;
      logic [7:0]  group_count;
      logic [63:0] group_total_bytes;
      logic [1:0]  status;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

### sv/offer_packet_parser.sv
// Offer packet parser top level. Accepts one packet byte per cycle while the queue
// is not full (req_stall); a byte's results pass through the queue and the rsp
// output register. A byte that ends both a string and the packet gives a character
// result, then a verdict; the QueueDepth-entry queue takes up that and rsp stalls.
// Reset (synchronous): clears parser state and queue, limits to 32, 64, 64.
// Depends on opp_pkg, opp_front, opp_queue and opp_back.
module offer_packet_parser #(
   parameter int QueueDepth = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [7:0]               csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  opp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output opp_pkg::rsp_payload_type rsp_payload
);

   opp_pkg::qstat_type qstat;
   opp_pkg::entry_type push_entry, head;
   logic               push, pop;

   assign req_stall = qstat.full;

   opp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .qstat       (qstat),
      .push        (push),
      .push_entry  (push_entry)
   );

   opp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (push_entry),
      .pop   (pop),
      .rdata (head),
      .qstat (qstat)
   );

   opp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### sv/opp_front.sv
// Front end of the offer packet parser: limit registers, byte parser, verdict.
// Depends on opp_pkg; pushes one entry per byte that yields results.
module opp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [7:0]               csr_wdata,
   input  logic                     req_valid,
   input  opp_pkg::req_payload_type req_payload,
   input  opp_pkg::qstat_type       qstat,
   output logic                     push,
   output opp_pkg::entry_type       push_entry
);

   logic [7:0]          dev_limit_ff, file_limit_ff, fold_limit_ff;
   opp_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]          field_count_ff, field_count_in;
   logic [7:0]          string_length_ff, string_length_in;
   logic [63:0]         size_accum_ff, size_accum_in;
   logic [7:0]          group_slot_ff, group_slot_in;
   logic [7:0]          group_members_ff, group_members_in;
   logic [63:0]         group_accum_ff, group_accum_in;
   logic [1:0]          error_code_ff, error_code_in;

   logic                accept;
   logic [7:0]          in_b;
   logic [8:0]          count_next;
   logic [7:0]          len_limit;
   opp_pkg::phase_type  str_phase, skip_phase;
   logic [1:0]          status;
   logic [1:0]          str_field;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !qstat.full;
   assign in_b      = req_payload.in_byte;
   assign count_next = {1'b0, field_count_ff} + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_limit_ff  <= opp_pkg::DeviceLimitReset;
         file_limit_ff <= opp_pkg::FileLimitReset;
         fold_limit_ff <= opp_pkg::FolderLimitReset;
      end else if (csr_valid) begin
         case (csr_index)
            opp_pkg::CSR_DEVICE_LIMIT: dev_limit_ff  <= csr_wdata;
            opp_pkg::CSR_FILE_LIMIT:   file_limit_ff <= csr_wdata;
            opp_pkg::CSR_FOLDER_LIMIT: fold_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      len_limit  = dev_limit_ff;
      str_phase  = opp_pkg::PH_DEV_STR;
      skip_phase = opp_pkg::PH_NAME_LEN;
      str_field  = opp_pkg::STR_DEVICE;
      unique case (phase_ff) inside
         opp_pkg::PH_NAME_LEN, opp_pkg::PH_NAME_STR: begin
            len_limit  = file_limit_ff;
            str_phase  = opp_pkg::PH_NAME_STR;
            skip_phase = opp_pkg::PH_FOLD_LEN;
            str_field  = opp_pkg::STR_FILE;
         end
         opp_pkg::PH_FOLD_LEN, opp_pkg::PH_FOLD_STR: begin
            len_limit  = fold_limit_ff;
            str_phase  = opp_pkg::PH_FOLD_STR;
            skip_phase = opp_pkg::PH_GIDX;
            str_field  = opp_pkg::STR_FOLDER;
         end
         default: ;
      endcase
   end

   always_comb begin
      phase_in         = phase_ff;
      field_count_in   = field_count_ff;
      string_length_in = string_length_ff;
      size_accum_in    = size_accum_ff;
      group_slot_in    = group_slot_ff;
      group_members_in = group_members_ff;
      group_accum_in   = group_accum_ff;
      error_code_in    = error_code_ff;
      push_entry       = '0;

      unique case (phase_ff) inside
         opp_pkg::PH_SIZE: begin
            size_accum_in[{field_count_ff[2:0], 3'b000} +: 8] =
               size_accum_ff[{field_count_ff[2:0], 3'b000} +: 8] | in_b;
            field_count_in = count_next[7:0];
            if (count_next >= {1'b0, opp_pkg::SizeBytes}) begin
               field_count_in = '0;
               phase_in       = opp_pkg::PH_DEV_LEN;
            end
         end
         opp_pkg::PH_DEV_LEN, opp_pkg::PH_NAME_LEN, opp_pkg::PH_FOLD_LEN: begin
            if (in_b > len_limit) begin
               phase_in      = opp_pkg::PH_FAIL;
               error_code_in = opp_pkg::ST_LIMIT;
            end else if (in_b == 8'd0) begin
               phase_in       = skip_phase;
               field_count_in = '0;
            end else begin
               string_length_in = in_b;
               field_count_in   = '0;
               phase_in         = str_phase;
            end
         end
         opp_pkg::PH_DEV_STR, opp_pkg::PH_NAME_STR, opp_pkg::PH_FOLD_STR: begin
            push_entry.has_char     = 1'b1;
            push_entry.string_field = str_field;
            push_entry.char_index   = field_count_ff;
            push_entry.char_value   = in_b;
            field_count_in          = count_next[7:0];
            if (count_next >= {1'b0, string_length_ff}) begin
               field_count_in = '0;
               phase_in       = skip_phase;
            end
         end
         opp_pkg::PH_GIDX: begin
            group_slot_in = in_b;
            phase_in      = opp_pkg::PH_GCNT;
         end
         opp_pkg::PH_GCNT: begin
            group_members_in = in_b;
            field_count_in   = '0;
            phase_in         = opp_pkg::PH_GTOT;
         end
         opp_pkg::PH_GTOT: begin
            group_accum_in[{field_count_ff[2:0], 3'b000} +: 8] =
               group_accum_ff[{field_count_ff[2:0], 3'b000} +: 8] | in_b;
            field_count_in = count_next[7:0];
            if (count_next >= {1'b0, opp_pkg::SizeBytes}) begin
               field_count_in = '0;
               phase_in       = opp_pkg::PH_DONE;
            end
         end
         default: ;
      endcase

      unique case (phase_in) inside
         opp_pkg::PH_FAIL:
            status = error_code_in;
         opp_pkg::PH_SIZE, opp_pkg::PH_DEV_LEN, opp_pkg::PH_DEV_STR,
         opp_pkg::PH_NAME_LEN, opp_pkg::PH_NAME_STR:
            status = opp_pkg::ST_HEAD;
         opp_pkg::PH_FOLD_LEN, opp_pkg::PH_DONE:
            status = opp_pkg::ST_OK;
         default:
            status = opp_pkg::ST_TAIL;
      endcase

      if (req_payload.end_of_packet) begin
         push_entry.has_verdict = 1'b1;
         push_entry.status      = status;
         if (status == opp_pkg::ST_OK) begin
            push_entry.file_size   = size_accum_in;
            push_entry.group_index = group_slot_in;
            push_entry.group_count = (group_members_in != 8'd0) ? group_members_in : 8'd1;
            push_entry.group_total_bytes =
               (group_accum_in != 64'd0) ? group_accum_in : size_accum_in;
         end
         phase_in         = opp_pkg::PH_SIZE;
         field_count_in   = '0;
         string_length_in = '0;
         size_accum_in    = '0;
         group_slot_in    = '0;
         group_members_in = '0;
         group_accum_in   = '0;
         error_code_in    = opp_pkg::ST_OK;
      end
   end

   assign push = accept && (push_entry.has_char || push_entry.has_verdict);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= opp_pkg::PH_SIZE;
         field_count_ff   <= '0;
         string_length_ff <= '0;
         size_accum_ff    <= '0;
         group_slot_ff    <= '0;
         group_members_ff <= '0;
         group_accum_ff   <= '0;
         error_code_ff    <= opp_pkg::ST_OK;
      end else if (accept) begin
         phase_ff         <= phase_in;
         field_count_ff   <= field_count_in;
         string_length_ff <= string_length_in;
         size_accum_ff    <= size_accum_in;
         group_slot_ff    <= group_slot_in;
         group_members_ff <= group_members_in;
         group_accum_ff   <= group_accum_in;
         error_code_ff    <= error_code_in;
      end
   end

endmodule

### sv/opp_queue.sv
// Short transaction queue between parser front end and result sequencer.
// Depends on opp_pkg and offer_packet_parser_macros.svh.
`include "offer_packet_parser_macros.svh"

module opp_queue #(
   parameter int Depth = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  opp_pkg::entry_type wdata,
   input  logic               pop,
   output opp_pkg::entry_type rdata,
   output opp_pkg::qstat_type qstat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastSlot  = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(Depth);

   opp_pkg::entry_type slot_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   assign qstat.full  = (count_ff == FullCount);
   assign qstat.empty = (count_ff == '0);
   assign rdata       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   `OPP_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !qstat.full || pop)
   `OPP_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, !qstat.empty)
   `OPP_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= FullCount)

endmodule

### sv/opp_back.sv
// Result sequencer: turns queued entries into string-byte and verdict results.
// Depends on opp_pkg and offer_packet_parser_macros.svh.
`include "offer_packet_parser_macros.svh"

module opp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  opp_pkg::entry_type       head,
   input  opp_pkg::qstat_type       qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output opp_pkg::rsp_payload_type rsp_payload
);

   logic                     rsp_valid_ff, rsp_valid_in;
   opp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                     second_ff, second_in;
   logic                     load;

   assign load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pop          = 1'b0;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = !qstat.empty;
         if (!qstat.empty) begin
            rsp_data_in = '0;
            if (head.has_char && !second_ff) begin
               rsp_data_in.kind         = opp_pkg::KIND_CHAR;
               rsp_data_in.string_field = head.string_field;
               rsp_data_in.char_index   = head.char_index;
               rsp_data_in.char_value   = head.char_value;
               rsp_data_in.last_of_run  = !head.has_verdict;
               if (head.has_verdict) begin
                  second_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               rsp_data_in.kind              = opp_pkg::KIND_VERDICT;
               rsp_data_in.file_size         = head.file_size;
               rsp_data_in.group_index       = head.group_index;
               rsp_data_in.group_count       = head.group_count;
               rsp_data_in.group_total_bytes = head.group_total_bytes;
               rsp_data_in.status            = head.status;
               rsp_data_in.last_of_run       = 1'b1;
               pop       = 1'b1;
               second_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `OPP_ASSERT_IMPLY(a_verdict_last, clock, reset,
      rsp_valid_ff && rsp_data_ff.kind == opp_pkg::KIND_VERDICT, rsp_data_ff.last_of_run)
   `OPP_ASSERT_IMPLY(a_split_pending, clock, reset,
      second_ff, !qstat.empty && head.has_char && head.has_verdict)
   `OPP_ASSERT_IMPLY(a_char_then_verdict, clock, reset,
      rsp_valid_ff && rsp_data_ff.kind == opp_pkg::KIND_CHAR && !rsp_data_ff.last_of_run,
      second_ff)

endmodule
